### rtl/core/vmc_pkg.sv
package vmc_pkg;

  localparam int unsigned LenLimit   = 127;
  localparam int unsigned LimitSq    = LenLimit * LenLimit;
  localparam int unsigned RootSteps  = 7;
  localparam int unsigned Lanes      = 3;
  localparam int unsigned Latency    = 2 * RootSteps + 4;

  typedef struct packed {
    logic signed [7:0] x_in;
    logic signed [7:0] y_in;
    logic signed [7:0] z_in;
  } in_t;

  typedef struct packed {
    logic signed [7:0] x_out;
    logic signed [7:0] y_out;
    logic signed [7:0] z_out;
    logic [6:0]        length;
    logic              was_clamped;
  } out_t;

  // Partial state of the search for the largest q with q*q*s <= target.
  // rem holds target - q*q*s, qs holds q*s.
  typedef struct packed {
    logic [27:0] rem;
    logic [22:0] qs;
    logic [6:0]  q;
    logic [15:0] s;
  } root_t;

endpackage

### rtl/core/vector_magnitude_clamp_core.sv
// Vector length clamp for 3D vectors of signed 8-bit components.
// Input channel: a word on in_data is taken at every rising edge where start
// is high and busy is low. busy is held low, so a word may enter every cycle.
// Result channel: out_strobe is high for exactly one cycle with the result on
// out_data; the receiver takes it in that cycle and cannot hold it off.
// The throughput is one vector per cycle. Results leave in input order.
// The pipeline is two squaring stages, a row of seven root cells per lane
// that resolve one bit of each scaled magnitude per cycle, two stages that
// form the new sum of squares, and seven further cells for the length.
// If the sum of squares exceeds 127*127 the components are scaled to
// length 127, truncated toward zero, and was_clamped is set.
// A synchronous reset (rst_n low) empties the pipeline: no strobe is given
// for words in flight. Payload registers are not reset.
module vector_magnitude_clamp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  vmc_pkg::in_t  in_data,
  output logic          out_strobe,
  output vmc_pkg::out_t out_data
);

  localparam int Steps = vmc_pkg::RootSteps;

  logic [vmc_pkg::Latency-1:0] vld_r;

  // Stage A
  logic signed [7:0] comp_in [vmc_pkg::Lanes];
  logic signed [7:0] comp_a_r [vmc_pkg::Lanes];
  logic        [7:0] mag_a [vmc_pkg::Lanes];
  logic       [14:0] sq_a_r [vmc_pkg::Lanes];

  // Stage B
  logic [15:0] s_b;
  vmc_pkg::root_t root_b_r [vmc_pkg::Lanes];
  logic signed [7:0] comp_b_r [vmc_pkg::Lanes];
  logic clamp_b_r;

  // Scaling cells
  vmc_pkg::root_t cell_r [Steps][vmc_pkg::Lanes];
  logic signed [7:0] comp_p_r [Steps][vmc_pkg::Lanes];
  logic clamp_p_r [Steps];

  // Stage C and D
  logic signed [7:0] res_c_r [vmc_pkg::Lanes];
  logic       [13:0] sq_c_r [vmc_pkg::Lanes];
  logic clamp_c_r;
  logic signed [7:0] res_d_r [vmc_pkg::Lanes];
  logic clamp_d_r;
  vmc_pkg::root_t len_d_r;

  // Length cells
  vmc_pkg::root_t len_r [Steps];
  logic signed [7:0] res_p_r [Steps][vmc_pkg::Lanes];
  logic clamp_l_r [Steps];

  logic signed [7:0] sel_c [vmc_pkg::Lanes];
  logic        [6:0] abs_c [vmc_pkg::Lanes];

  assign busy = 1'b0;
  assign comp_in[0] = in_data.x_in;
  assign comp_in[1] = in_data.y_in;
  assign comp_in[2] = in_data.z_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[vmc_pkg::Latency-2:0], start & ~busy};
    end
  end

  always_comb begin
    s_b = 16'(sq_a_r[0]) + 16'(sq_a_r[1]) + 16'(sq_a_r[2]);
  end

  for (genvar l = 0; l < vmc_pkg::Lanes; l++) begin : g_lane
    always_comb begin
      mag_a[l] = comp_in[l][7] ? 8'(-comp_in[l]) : comp_in[l];
    end

    always_ff @(posedge clk) begin
      comp_a_r[l]     <= comp_in[l];
      sq_a_r[l]       <= 15'(mag_a[l] * mag_a[l]);
      root_b_r[l].rem <= 28'(sq_a_r[l] * 15'(vmc_pkg::LimitSq));
      root_b_r[l].qs  <= '0;
      root_b_r[l].q   <= '0;
      root_b_r[l].s   <= s_b;
      comp_b_r[l]     <= comp_a_r[l];
    end

    for (genvar j = 0; j < Steps; j++) begin : g_cell
      if (j == 0) begin : g_first
        vmc_root_cell u_cell (
          .clk  (clk),
          .k    (3'(Steps - 1 - j)),
          .cur  (root_b_r[l]),
          .nxt_r(cell_r[j][l])
        );
        always_ff @(posedge clk) begin
          comp_p_r[j][l] <= comp_b_r[l];
        end
      end else begin : g_rest
        vmc_root_cell u_cell (
          .clk  (clk),
          .k    (3'(Steps - 1 - j)),
          .cur  (cell_r[j-1][l]),
          .nxt_r(cell_r[j][l])
        );
        always_ff @(posedge clk) begin
          comp_p_r[j][l] <= comp_p_r[j-1][l];
        end
      end
    end

    always_comb begin
      if (clamp_p_r[Steps-1]) begin
        sel_c[l] = comp_p_r[Steps-1][l][7] ? -$signed({1'b0, cell_r[Steps-1][l].q})
                                          : $signed({1'b0, cell_r[Steps-1][l].q});
      end else begin
        sel_c[l] = comp_p_r[Steps-1][l];
      end
      abs_c[l] = sel_c[l][7] ? 7'(-sel_c[l]) : sel_c[l][6:0];
    end

    always_ff @(posedge clk) begin
      res_c_r[l] <= sel_c[l];
      sq_c_r[l]  <= 14'(abs_c[l] * abs_c[l]);
      res_d_r[l] <= res_c_r[l];
    end

    for (genvar j = 0; j < Steps; j++) begin : g_res
      if (j == 0) begin : g_first
        always_ff @(posedge clk) res_p_r[j][l] <= res_d_r[l];
      end else begin : g_rest
        always_ff @(posedge clk) res_p_r[j][l] <= res_p_r[j-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    clamp_b_r   <= s_b > 16'(vmc_pkg::LimitSq);
    clamp_c_r   <= clamp_p_r[Steps-1];
    clamp_d_r   <= clamp_c_r;
    len_d_r.rem <= 28'(16'(sq_c_r[0]) + 16'(sq_c_r[1]) + 16'(sq_c_r[2]));
    len_d_r.qs  <= '0;
    len_d_r.q   <= '0;
    len_d_r.s   <= 16'd1;
  end

  for (genvar j = 0; j < Steps; j++) begin : g_len
    if (j == 0) begin : g_first
      vmc_root_cell u_cell (
        .clk  (clk),
        .k    (3'(Steps - 1 - j)),
        .cur  (len_d_r),
        .nxt_r(len_r[j])
      );
      always_ff @(posedge clk) begin
        clamp_p_r[j] <= clamp_b_r;
        clamp_l_r[j] <= clamp_d_r;
      end
    end else begin : g_rest
      vmc_root_cell u_cell (
        .clk  (clk),
        .k    (3'(Steps - 1 - j)),
        .cur  (len_r[j-1]),
        .nxt_r(len_r[j])
      );
      always_ff @(posedge clk) begin
        clamp_p_r[j] <= clamp_p_r[j-1];
        clamp_l_r[j] <= clamp_l_r[j-1];
      end
    end
  end

  assign out_strobe           = vld_r[vmc_pkg::Latency-1];
  assign out_data.x_out       = res_p_r[Steps-1][0];
  assign out_data.y_out       = res_p_r[Steps-1][1];
  assign out_data.z_out       = res_p_r[Steps-1][2];
  assign out_data.length      = len_r[Steps-1].q;
  assign out_data.was_clamped = clamp_l_r[Steps-1];

endmodule

### rtl/core/vmc_root_cell.sv
module vmc_root_cell (
  input  logic                 clk,
  input  logic [2:0]           k,
  input  vmc_pkg::root_t       cur,
  output vmc_pkg::root_t       nxt_r
);

  logic [30:0]    trial;
  logic [30:0]    qs_sh;
  logic [30:0]    s_sh;
  logic           take;
  vmc_pkg::root_t nxt_nxt;

  // Setting bit k of q raises q*q*s by 2*q*s*2^k + s*4^k.
  always_comb begin
    qs_sh   = {8'd0, cur.qs} << ({1'b0, k} + 4'd1);
    s_sh    = {15'd0, cur.s} << ({1'b0, k} << 1);
    trial   = qs_sh + s_sh;
    take    = trial <= {3'd0, cur.rem};
    nxt_nxt = cur;
    if (take) begin
      nxt_nxt.rem = cur.rem - trial[27:0];
      nxt_nxt.qs  = cur.qs + 23'((({7'd0, cur.s}) << k));
      nxt_nxt.q   = cur.q | 7'(7'd1 << k);
    end
  end

  always_ff @(posedge clk) begin
    nxt_r <= nxt_nxt;
  end

endmodule

### rtl/core/vmc_checker.sv
module vmc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input vmc_pkg::out_t out_data
);

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##18 out_strobe)
    else $error("word accepted without result");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 18))
    else $error("result without accepted word");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.x_out != 8'sh80 && out_data.y_out != 8'sh80 &&
                    out_data.z_out != 8'sh80))
    else $error("component out of range");

endmodule

bind vector_magnitude_clamp_core vmc_checker u_vmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  vmc_pkg::in_t in_data = '0;
  logic out_strobe;
  vmc_pkg::out_t out_data;

  vector_magnitude_clamp_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    vmc_pkg::in_t  vec;
    logic          known;
    vmc_pkg::out_t res;
  } row_t;

  vmc_pkg::out_t clamped_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int clamped_seen = 0;
  longint cycles = 0;

  function automatic int unsigned int_root(int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int scaled(int c, int unsigned sum);
    int unsigned mag;
    longint unsigned a;
    int unsigned q;
    mag = (c < 0) ? -c : c;
    a = mag * vmc_pkg::LenLimit;
    q = int_root(int'((a * a) / sum));
    return (c < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic vmc_pkg::out_t clamp_vector(vmc_pkg::in_t v);
    vmc_pkg::out_t r;
    int x, y, z;
    int unsigned sum, nsum;
    x = v.x_in;
    y = v.y_in;
    z = v.z_in;
    sum = x * x + y * y + z * z;
    r.was_clamped = (sum > vmc_pkg::LimitSq);
    if (r.was_clamped) begin
      x = scaled(x, sum);
      y = scaled(y, sum);
      z = scaled(z, sum);
    end
    nsum = x * x + y * y + z * z;
    r.x_out = x[7:0];
    r.y_out = y[7:0];
    r.z_out = z[7:0];
    r.length = 7'(int_root(nsum));
    return r;
  endfunction

  function automatic row_t mk(int x, int y, int z, logic k, int xo, int yo, int zo,
                              int len, logic cl);
    row_t r;
    r.vec = '{x[7:0], y[7:0], z[7:0]};
    r.known = k;
    r.res = '{xo[7:0], yo[7:0], zo[7:0], len[6:0], cl};
    return r;
  endfunction

  row_t vec_table[$];

  // Leaves start high; the caller drops it when the input goes idle.
  task automatic send_word(vmc_pkg::in_t v, logic known, vmc_pkg::out_t res);
    vmc_pkg::out_t want;
    want = known ? res : clamp_vector(v);
    if (known && want !== clamp_vector(v)) begin
      $display("%0t: table row disagrees with predictor for %h, expected %p actual %p",
               $time, v, clamp_vector(v), want);
      errors++;
    end
    start <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    clamped_q.push_back(want);
    words_sent++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (clamped_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %p", $time, out_data);
        errors++;
      end else begin
        vmc_pkg::out_t e;
        e = clamped_q.pop_front();
        if (out_data !== e) begin
          $display("%0t: mismatch, expected %p actual %p", $time, e, out_data);
          errors++;
        end
        if (e.was_clamped) clamped_seen++;
        words_checked++;
      end
    end
  end

  initial begin
    vmc_pkg::in_t v;
    int wait_n;
    vec_table.push_back(mk(0, 0, 0, 1, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(127, 0, 0, 1, 127, 0, 0, 127, 0));
    vec_table.push_back(mk(-127, 0, 0, 1, -127, 0, 0, 127, 0));
    vec_table.push_back(mk(0, 127, 0, 1, 0, 127, 0, 127, 0));
    vec_table.push_back(mk(0, 0, -127, 1, 0, 0, -127, 127, 0));
    vec_table.push_back(mk(-128, 0, 0, 1, -127, 0, 0, 127, 1));
    vec_table.push_back(mk(0, -128, 0, 1, 0, -127, 0, 127, 1));
    vec_table.push_back(mk(0, 0, -128, 1, 0, 0, -127, 127, 1));
    vec_table.push_back(mk(1, 1, 1, 1, 1, 1, 1, 1, 0));
    vec_table.push_back(mk(-1, -1, -1, 1, -1, -1, -1, 1, 0));
    vec_table.push_back(mk(127, 127, 127, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(-128, -128, -128, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(-128, 127, -128, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(127, 1, 0, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(72, 72, 71, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(-73, 73, 73, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(100, -50, 25, 0, 0, 0, 0, 0, 0));
    vec_table.push_back(mk(3, 4, 12, 1, 3, 4, 12, 13, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (vec_table[i]) send_word(vec_table[i].vec, vec_table[i].known, vec_table[i].res);
    for (int n = 0; n < 900; n++) begin
      // The middle third runs back to back without gaps.
      if ((n < 300 || n > 600) && $urandom_range(99) < 9) begin
        wait_n = $urandom_range(1, 5);
        start <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      v = 24'($urandom);
      if ($urandom_range(3) == 0) begin
        // Short vectors, so that the unscaled path is well exercised.
        v.x_in = $signed(8'($urandom_range(0, 146))) - 8'sd73;
        v.y_in = $signed(8'($urandom_range(0, 146))) - 8'sd73;
        v.z_in = $signed(8'($urandom_range(0, 146))) - 8'sd73;
      end
      send_word(v, 1'b0, '0);
    end
    start <= 1'b0;
    while (clamped_q.size() != 0) @(posedge clk);
    repeat (vmc_pkg::Latency + 10) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d of them scaled.",
             words_sent, words_checked, clamped_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/vmc_pkg.sv
rtl/core/vmc_root_cell.sv
rtl/core/vector_magnitude_clamp_core.sv
rtl/core/vmc_checker.sv
bench/tb_top.sv
